### sv/ipvdmr_pkg.sv
// ----------------------------------------------------------------------------
// ipvdmr_pkg: shared types and constants of the IPv4 destination rewriter
// Frame limits, hold buffer depth, checksum accumulator width and the
// control bundle that the checksum lanes share.
// ----------------------------------------------------------------------------
package ipvdmr_pkg;

    localparam int MAX_FRAME_BYTES = 2048;
    localparam int HOLD_WORDS      = 19;

    // Word counter must reach ceil(MAX_FRAME_BYTES / 4)
    localparam int POS_W  = $clog2((MAX_FRAME_BYTES + 3) / 4 + 1);
    localparam int HOLD_W = $clog2(HOLD_WORDS);
    // Up to 30 header halfwords of 16 bits each
    localparam int ACC_W  = 21;

    // Configuration register indexes
    localparam logic [1:0] CFG_MASK_KEY  = 2'd0;
    localparam logic [1:0] CFG_REPL_ADDR = 2'd1;
    localparam logic [1:0] CFG_ETHERTYPE = 2'd2;

    // Halfword positions inside the IPv4 header (two bytes each from byte 14)
    localparam logic [4:0] HW_CHECKSUM = 5'd5;
    localparam logic [4:0] HW_DST_HI   = 5'd8;
    localparam logic [4:0] HW_DST_LO   = 5'd9;
    localparam logic [4:0] HW_OPT_HI   = 5'd10;
    localparam logic [4:0] HW_OPT_LO   = 5'd11;

    // Control shared by both checksum lanes for the word in transfer
    typedef struct packed {
        logic [HOLD_W-1:0] word_idx;
        logic [3:0]        ihl;
        logic [7:0]        key;
        logic [31:0]       repl;
        logic [31:0]       dest;
    } lane_ctl_t;

endpackage

### sv/ipvdmr_cksum_lane.sv
// ----------------------------------------------------------------------------
// ipvdmr_cksum_lane: one halfword lane of the header checksum
// Maps a halfword of the incoming word to its header position, substitutes
// the rewritten value and gates it by the header length.
// ----------------------------------------------------------------------------
module ipvdmr_cksum_lane
(
    input  logic                  hi_lane,
    input  logic [15:0]           half,
    input  ipvdmr_pkg::lane_ctl_t ctl,
    output logic [15:0]           contrib
);

    logic [5:0]  twice_idx;
    logic [5:0]  hw_pos;
    logic        in_header;
    logic [15:0] kk;
    logic [15:0] value;

    assign twice_idx = {ctl.word_idx, 1'b0};
    assign kk        = {ctl.key, ctl.key};

    // Locate the halfword relative to frame byte 14
    always_comb
    begin
        if (hi_lane)
        begin
            in_header = (ctl.word_idx >= 5'd4);
            hw_pos    = twice_idx - 6'd7;
        end
        else
        begin
            in_header = (ctl.word_idx >= 5'd3);
            hw_pos    = twice_idx - 6'd6;
        end
        if (hw_pos >= {1'b0, ctl.ihl, 1'b0})
        begin
            in_header = 1'b0;
        end
    end

    // Substitute the fields that the rewrite replaces
    always_comb
    begin
        case (hw_pos[4:0])
            ipvdmr_pkg::HW_CHECKSUM: value = 16'h0000;
            ipvdmr_pkg::HW_DST_HI:   value = ctl.repl[31:16];
            ipvdmr_pkg::HW_DST_LO:   value = ctl.repl[15:0];
            ipvdmr_pkg::HW_OPT_HI:   value = ctl.dest[31:16] ^ kk;
            ipvdmr_pkg::HW_OPT_LO:   value = ctl.dest[15:0] ^ kk;
            default:                 value = half;
        endcase
    end

    assign contrib = in_header ? value : 16'h0000;

endmodule

### sv/ipvdmr_cksum_merge.sv
// ----------------------------------------------------------------------------
// ipvdmr_cksum_merge: merge of the checksum lanes
// Adds both lane results into the running header sum and folds the sum
// into the final ones' complement checksum.
// ----------------------------------------------------------------------------
module ipvdmr_cksum_merge
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        start,
    input  logic [15:0] lane_hi,
    input  logic [15:0] lane_lo,
    output logic [15:0] cksum
);

    logic [ipvdmr_pkg::ACC_W-1:0] acc_reg;
    logic [ipvdmr_pkg::ACC_W-1:0] acc_next;
    logic [ipvdmr_pkg::ACC_W-1:0] lanes_sum;
    logic [16:0]                  fold1;
    logic [15:0]                  fold2;

    assign lanes_sum = ipvdmr_pkg::ACC_W'(lane_hi) + ipvdmr_pkg::ACC_W'(lane_lo);

    // Restart the sum on the first word of a frame
    always_comb
    begin
        acc_next = acc_reg;
        if (en)
        begin
            acc_next = start ? lanes_sum : acc_reg + lanes_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    // Fold carries twice, then complement
    assign fold1 = 17'(acc_reg[15:0]) + 17'(acc_reg[ipvdmr_pkg::ACC_W-1:16]);
    assign fold2 = fold1[15:0] + 16'(fold1[16]);
    assign cksum = ~fold2;

endmodule

### sv/ipv4_destination_masking_rewriter.sv
// ----------------------------------------------------------------------------
// ipv4_destination_masking_rewriter: IPv4 destination masking rewriter
// Holds the leading words of each frame, rewrites destination, option bytes
// and checksum of matching frames, then flushes; other words stream through.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one 32-bit frame word per
//   transfer, first byte in bits 31..24, with byte_count and last_word.
//   Output channel (out_valid/out_stall) carries the resulting words.
//   Configuration (cfg_valid/cfg_ready, always ready) writes mask_key,
//   replacement_address and match_ethertype; write only while idle.
//   Streaming words pass through the output register, so a frame body
//   moves at one word per cycle while the receiver does not stall.
//   Header words are held without output until the header is complete
//   (at most 19 words); the flush then sends one held word per cycle while
//   the receiver does not stall, and the input is stalled during the flush.
//   The checksum is accumulated by two halfword lanes as words arrive.
//   Reset clears all control state and loads the register defaults.
//   When the receiver stalls, the output register holds its word and the
//   input stalls as soon as a new output word cannot be loaded.
// ----------------------------------------------------------------------------
module ipv4_destination_masking_rewriter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] data_word,
    input  logic [2:0]  byte_count,
    input  logic        last_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] out_word,
    output logic [2:0]  out_byte_count,
    output logic        out_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int POS_W  = ipvdmr_pkg::POS_W;
    localparam int HOLD_W = ipvdmr_pkg::HOLD_W;
    localparam int BASE_W = POS_W + 3;

    localparam logic [1:0] ST_COLLECT = 2'd0;
    localparam logic [1:0] ST_STREAM  = 2'd1;
    localparam logic [1:0] ST_DISCARD = 2'd2;
    localparam logic [1:0] ST_FLUSH   = 2'd3;

    localparam logic [BASE_W-1:0] MAX_B = BASE_W'(ipvdmr_pkg::MAX_FRAME_BYTES);
    localparam logic [HOLD_W-1:0] LAST_SLOT = HOLD_W'(ipvdmr_pkg::HOLD_WORDS - 1);

    // Configuration registers
    logic [7:0]  key_reg;
    logic [31:0] repl_reg;
    logic [15:0] etype_reg;

    // Control state
    logic [1:0]        state_reg;
    logic [1:0]        after_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [HOLD_W-1:0] held_reg;
    logic [HOLD_W-1:0] fptr_reg;
    logic [2:0]        tail_reg;
    logic [3:0]        ihl_reg;
    logic              final_reg;
    logic              rewrite_reg;

    // Payload storage
    logic [31:0] hold_mem [ipvdmr_pkg::HOLD_WORDS];
    logic [31:0] dest_reg;

    // Output register
    logic        ov_reg;
    logic [31:0] ow_reg;
    logic [2:0]  oc_reg;
    logic        ol_reg;

    // Input word decode
    logic              in_xfer;
    logic              load_ok;
    logic [2:0]        cnt_eff;
    logic [BASE_W-1:0] base;
    logic              over;
    logic              cut;
    logic [2:0]        cnt_out;
    logic              end_out;
    logic [1:0]        next_mode;
    logic [HOLD_W-1:0] slot;
    logic [7:0]        total;
    logic [7:0]        need;
    logic              mismatch;
    logic              rewrite_now;
    logic              flush_now;

    // Flush read path
    logic [31:0] fword;
    logic [31:0] fword_mod;
    logic        flast_slot;
    logic [15:0] kk;

    // Checksum lanes
    ipvdmr_pkg::lane_ctl_t lane_ctl;
    logic [15:0]           lane_hi;
    logic [15:0]           lane_lo;
    logic [15:0]           cksum;
    logic                  collect_xfer;

    assign cfg_ready = 1'b1;
    assign load_ok   = !ov_reg || !out_stall;
    assign in_stall  = (state_reg == ST_FLUSH) || ((state_reg == ST_STREAM) && !load_ok);
    assign in_xfer   = in_valid && !in_stall;

    // Normalize the byte count and apply the frame length limit
    always_comb
    begin
        cnt_eff = byte_count;
        if (!last_word || byte_count == 3'd0 || byte_count > 3'd4)
        begin
            cnt_eff = 3'd4;
        end
        base    = {1'b0, pos_reg, 2'b00};
        over    = (base >= MAX_B);
        cut     = ((base + BASE_W'(cnt_eff)) >= MAX_B);
        cnt_out = cut ? 3'(MAX_B - base) : cnt_eff;
        end_out = last_word || cut;
        next_mode = (cut && !last_word) ? ST_DISCARD : ST_COLLECT;
    end

    // Decide when the held header is flushed and whether it is rewritten
    always_comb
    begin
        slot  = (held_reg >= HOLD_W'(ipvdmr_pkg::HOLD_WORDS)) ? LAST_SLOT : held_reg;
        total = {1'b0, slot, 2'b00} + 8'(cnt_out);
        need  = 8'd14 + {2'b00, ihl_reg, 2'b00};
        if (need < 8'd38)
        begin
            need = 8'd38;
        end
        mismatch    = (slot == 5'd3) && (total >= 8'd16) && (data_word[31:16] != etype_reg);
        rewrite_now = (slot >= 5'd4) && (total >= need);
        flush_now   = mismatch || rewrite_now || end_out;
    end

    // Feed the checksum lanes with the word in transfer
    always_comb
    begin
        lane_ctl.word_idx = slot;
        lane_ctl.ihl      = (slot == 5'd3) ? data_word[11:8] : ihl_reg;
        lane_ctl.key      = key_reg;
        lane_ctl.repl     = repl_reg;
        lane_ctl.dest     = dest_reg;
    end

    assign collect_xfer = in_xfer && (state_reg == ST_COLLECT) && !over;

    ipvdmr_cksum_lane u_lane_hi
    (
        .hi_lane (1'b1),
        .half    (data_word[31:16]),
        .ctl     (lane_ctl),
        .contrib (lane_hi)
    );

    ipvdmr_cksum_lane u_lane_lo
    (
        .hi_lane (1'b0),
        .half    (data_word[15:0]),
        .ctl     (lane_ctl),
        .contrib (lane_lo)
    );

    ipvdmr_cksum_merge u_merge
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (collect_xfer),
        .start   (slot == '0),
        .lane_hi (lane_hi),
        .lane_lo (lane_lo),
        .cksum   (cksum)
    );

    // Build the flushed word, rewriting header words when required
    assign kk         = {key_reg, key_reg};
    assign fword      = hold_mem[fptr_reg];
    assign flast_slot = (fptr_reg == held_reg - 5'd1);

    always_comb
    begin
        fword_mod = fword;
        if (rewrite_reg)
        begin
            case (fptr_reg)
                5'd6:    fword_mod = {cksum, fword[15:0]};
                5'd7:    fword_mod = {fword[31:16], repl_reg[31:16]};
                5'd8:    fword_mod = {repl_reg[15:0], dest_reg[31:16] ^ kk};
                5'd9:    fword_mod = {dest_reg[15:0] ^ kk, fword[15:0]};
                default: fword_mod = fword;
            endcase
        end
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= 8'hAA;
            repl_reg  <= 32'hFFFF_FFFF;
            etype_reg <= 16'h0800;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ipvdmr_pkg::CFG_MASK_KEY:  key_reg   <= cfg_data[7:0];
                ipvdmr_pkg::CFG_REPL_ADDR: repl_reg  <= cfg_data;
                ipvdmr_pkg::CFG_ETHERTYPE: etype_reg <= cfg_data[15:0];
                default:                   key_reg   <= key_reg;
            endcase
        end
    end

    // Hold header words and capture the original destination
    always_ff @(posedge clk)
    begin
        if (collect_xfer)
        begin
            hold_mem[slot] <= data_word;
            if (slot == 5'd7)
            begin
                dest_reg[31:16] <= data_word[15:0];
            end
            if (slot == 5'd8)
            begin
                dest_reg[15:0] <= data_word[31:16];
            end
        end
    end

    // Frame sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_COLLECT;
            after_reg   <= ST_COLLECT;
            pos_reg     <= '0;
            held_reg    <= '0;
            fptr_reg    <= '0;
            tail_reg    <= 3'd4;
            ihl_reg     <= '0;
            final_reg   <= 1'b0;
            rewrite_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_DISCARD:
                begin
                    if (in_xfer && last_word)
                    begin
                        state_reg <= ST_COLLECT;
                        pos_reg   <= '0;
                    end
                end
                ST_FLUSH:
                begin
                    if (load_ok)
                    begin
                        fptr_reg <= fptr_reg + 5'd1;
                        if (flast_slot)
                        begin
                            state_reg <= after_reg;
                            held_reg  <= '0;
                        end
                    end
                end
                default:
                begin
                    if (in_xfer)
                    begin
                        if (over)
                        begin
                            state_reg <= last_word ? ST_COLLECT : ST_DISCARD;
                            pos_reg   <= '0;
                            held_reg  <= '0;
                        end
                        else if (state_reg == ST_STREAM)
                        begin
                            pos_reg <= pos_reg + 1'b1;
                            if (end_out)
                            begin
                                state_reg <= next_mode;
                                pos_reg   <= '0;
                            end
                        end
                        else
                        begin
                            pos_reg  <= pos_reg + 1'b1;
                            held_reg <= slot + 5'd1;
                            tail_reg <= cnt_out;
                            if (slot == 5'd3)
                            begin
                                ihl_reg <= data_word[11:8];
                            end
                            if (flush_now)
                            begin
                                state_reg   <= ST_FLUSH;
                                fptr_reg    <= '0;
                                final_reg   <= end_out;
                                rewrite_reg <= rewrite_now && !mismatch;
                                after_reg   <= end_out ? next_mode : ST_STREAM;
                                if (end_out)
                                begin
                                    pos_reg <= '0;
                                end
                            end
                        end
                    end
                end
            endcase
        end
    end

    // Output register: load streamed or flushed words, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (load_ok)
        begin
            ov_reg <= (state_reg == ST_FLUSH)
                   || (in_xfer && (state_reg == ST_STREAM) && !over);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            if (state_reg == ST_FLUSH)
            begin
                ow_reg <= fword_mod;
                oc_reg <= flast_slot ? tail_reg : 3'd4;
                ol_reg <= final_reg && flast_slot;
            end
            else
            begin
                ow_reg <= data_word;
                oc_reg <= cnt_out;
                ol_reg <= end_out;
            end
        end
    end

    assign out_valid      = ov_reg;
    assign out_word       = ow_reg;
    assign out_byte_count = oc_reg;
    assign out_last       = ol_reg;

endmodule
